FILE: rtl/core/tspc_pkg.sv
// constants shared by the traffic signal phase controller
// no dependencies
package tspc_pkg;

    localparam int TIME_BITS_DEF = 30;
    localparam int SEC_BITS      = 30;
    localparam int CODE_BITS     = 31;
    localparam int ORDER_BITS    = 12;
    localparam int PTIME_BITS    = 30;
    localparam int YTIME_BITS    = 20;
    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 32;
    localparam int GUARD_MAX     = 9;

    localparam logic [ORDER_BITS-1:0] RESET_ORDER  = 12'd1672;
    localparam logic [PTIME_BITS-1:0] RESET_GREEN  = 30'd1000000000;
    localparam logic [YTIME_BITS-1:0] RESET_YELLOW = 20'd5;

    localparam logic [CODE_BITS-1:0] CODE_RED   = 31'h7FFF_FFFF;
    localparam logic [CODE_BITS-1:0] CODE_RIGHT = 31'h7FFF_FFFE;

    localparam logic [2:0] REG_ORDER  = 3'd0;
    localparam logic [2:0] REG_PTIME0 = 3'd1;
    localparam logic [2:0] REG_PTIME1 = 3'd2;
    localparam logic [2:0] REG_PTIME2 = 3'd3;
    localparam logic [2:0] REG_PTIME3 = 3'd4;
    localparam logic [2:0] REG_YELLOW = 3'd5;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] DIR_UTURN    = 2'd0;
    localparam logic [1:0] DIR_LEFT     = 2'd1;
    localparam logic [1:0] DIR_STRAIGHT = 2'd2;
    localparam logic [1:0] DIR_RIGHT    = 2'd3;

endpackage

FILE: rtl/core/traffic_signal_phase_controller_core.sv
// a query transaction gives its result in the cycle after acceptance
// a tick that crosses no boundary goes through the compare and finish states; one
// that crosses also goes through the cycle-length sum, the bitwise remainder and the
// boundary steps, all on one shared add/subtract unit; one transaction in flight at a time
// reset: aresetn synchronous active low, config and control registers to their defaults,
// phase slot 0 in green with its full time
module traffic_signal_phase_controller_core #(
    parameter int TIME_BITS = tspc_pkg::TIME_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_kind,
    input  logic [tspc_pkg::SEC_BITS-1:0]          s_elapsed,
    input  logic [1:0]                             s_from_leg,
    input  logic [1:0]                             s_to_leg,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_can_go,
    output logic signed [tspc_pkg::CODE_BITS-1:0]  m_remaining_code,
    output logic [1:0]                             m_phase_now,
    output logic                                   m_yellow_now,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tspc_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [tspc_pkg::DATA_BITS-1:0]         pwdata,
    output logic [tspc_pkg::DATA_BITS-1:0]         prdata,
    output logic                                   pready
);
    import tspc_pkg::*;

    localparam int CW     = TIME_BITS + 3;
    localparam int DW     = ((TIME_BITS > SEC_BITS) ? TIME_BITS : SEC_BITS) + 4;
    localparam int STEP_W = $clog2(SEC_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_LOOP = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [ORDER_BITS-1:0] order_reg, order_next;
    logic [PTIME_BITS-1:0] ptime_reg [4];
    logic [PTIME_BITS-1:0] ptime_next [4];
    logic [YTIME_BITS-1:0] ytime_reg, ytime_next;

    logic [2:0]           state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [1:0]           phase_reg, phase_next;
    logic                 yellow_reg, yellow_next;
    logic [SEC_BITS-1:0]  sec_reg, sec_next;
    logic [CW-1:0]        cyc_reg, cyc_next;
    logic [CW-1:0]        pr_reg, pr_next;

    logic                 mv_reg, mv_next;
    logic                 go_reg, go_next;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [1:0]           mphase_reg, mphase_next;
    logic                 myellow_reg, myellow_next;

    logic          op_sub;
    logic [DW-1:0] op_a, op_b;
    logic [DW:0]   alu_full;
    logic [DW-1:0] alu_res;
    logic          alu_ge;

    logic          cfg_wr;
    logic          in_acc;
    logic [CW:0]   pr_sh;
    logic [1:0]    q_dir;
    logic [2:0]    q_status;
    logic          q_turn_left;
    logic          q_ok;
    logic [1:0]    phase_inc;

    function automatic logic [TIME_BITS-1:0] sat_len(input logic [PTIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] v;
        v = TIME_BITS'(t);
        return (v == '0) ? TIME_BITS'(1) : v;
    endfunction

    logic [TIME_BITS-1:0] ylen;
    logic [TIME_BITS-1:0] glen_step;
    logic [TIME_BITS-1:0] glen_inc;

    assign ylen      = sat_len(PTIME_BITS'(ytime_reg));
    assign glen_step = sat_len(ptime_reg[step_reg[1:0]]);
    assign phase_inc = phase_reg + 2'd1;
    assign glen_inc  = sat_len(ptime_reg[phase_inc]);

    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE) && (!mv_reg || m_ready);
    assign in_acc  = s_valid && s_ready;

    assign m_valid          = mv_reg;
    assign m_can_go         = go_reg;
    assign m_remaining_code = code_reg;
    assign m_phase_now      = mphase_reg;
    assign m_yellow_now     = myellow_reg;

    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_ORDER:  prdata = DATA_BITS'(order_reg);
            REG_PTIME0: prdata = DATA_BITS'(ptime_reg[0]);
            REG_PTIME1: prdata = DATA_BITS'(ptime_reg[1]);
            REG_PTIME2: prdata = DATA_BITS'(ptime_reg[2]);
            REG_PTIME3: prdata = DATA_BITS'(ptime_reg[3]);
            REG_YELLOW: prdata = DATA_BITS'(ytime_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        order_next = order_reg;
        ptime_next = ptime_reg;
        ytime_next = ytime_reg;
        if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_ORDER:  order_next    = pwdata[ORDER_BITS-1:0];
                REG_PTIME0: ptime_next[0] = pwdata[PTIME_BITS-1:0];
                REG_PTIME1: ptime_next[1] = pwdata[PTIME_BITS-1:0];
                REG_PTIME2: ptime_next[2] = pwdata[PTIME_BITS-1:0];
                REG_PTIME3: ptime_next[3] = pwdata[PTIME_BITS-1:0];
                REG_YELLOW: ytime_next    = pwdata[YTIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // shared add/subtract unit
    assign pr_sh = {pr_reg, sec_reg[SEC_BITS-1]};

    always_comb begin
        op_sub = 1'b1;
        op_a   = DW'(sec_reg);
        op_b   = DW'(rem_reg);
        unique case (state_reg)
            ST_SUM: begin
                op_sub = 1'b0;
                op_a   = DW'(cyc_reg);
                op_b   = DW'(glen_step);
            end
            ST_DIV: begin
                op_a = DW'(pr_sh);
                op_b = DW'(cyc_reg);
            end
            ST_FIN: begin
                op_a = DW'(rem_reg);
                op_b = DW'(sec_reg);
            end
            default: ;
        endcase
    end

    assign alu_full = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (DW + 1)'(op_sub);
    assign alu_res  = alu_full[DW-1:0];
    assign alu_ge   = alu_full[DW];

    // query decode
    assign q_dir       = s_to_leg - s_from_leg;
    assign q_status    = order_reg[3 * phase_reg +: 3];
    assign q_turn_left = (q_dir == DIR_LEFT) || (q_dir == DIR_UTURN);

    always_comb begin
        if (!q_status[2]) begin
            q_ok = (s_from_leg[0] == q_status[1]) &&
                   (!q_status[0] ? q_turn_left : (q_dir == DIR_STRAIGHT));
        end else begin
            q_ok = (s_from_leg == q_status[1:0]);
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        rem_next     = rem_reg;
        phase_next   = phase_reg;
        yellow_next  = yellow_reg;
        sec_next     = sec_reg;
        cyc_next     = cyc_reg;
        pr_next      = pr_reg;
        mv_next      = mv_reg && !m_ready;
        go_next      = go_reg;
        code_next    = code_reg;
        mphase_next  = mphase_reg;
        myellow_next = myellow_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_kind == KIND_TICK) begin
                        sec_next   = s_elapsed;
                        state_next = ST_CMP;
                    end else begin
                        mv_next      = 1'b1;
                        mphase_next  = phase_reg;
                        myellow_next = yellow_reg;
                        if (yellow_reg) begin
                            go_next   = 1'b0;
                            code_next = CODE_BITS'(rem_reg);
                        end else if (q_dir == DIR_RIGHT) begin
                            go_next   = 1'b1;
                            code_next = CODE_RIGHT;
                        end else begin
                            go_next   = q_ok;
                            code_next = q_ok ? CODE_BITS'(rem_reg) : CODE_RED;
                        end
                    end
                end
            end
            ST_CMP, ST_LOOP: begin
                if (state_reg == ST_LOOP && step_reg == STEP_W'(GUARD_MAX)) begin
                    state_next = ST_FIN;
                end else if (alu_ge) begin
                    sec_next = SEC_BITS'(alu_res);
                    if (!yellow_reg) begin
                        yellow_next = 1'b1;
                        rem_next    = ylen;
                    end else begin
                        yellow_next = 1'b0;
                        phase_next  = phase_inc;
                        rem_next    = glen_inc;
                    end
                    if (state_reg == ST_CMP) begin
                        state_next = ST_SUM;
                        step_next  = '0;
                        cyc_next   = CW'(ylen) << 2;
                    end else begin
                        step_next = step_reg + STEP_W'(1);
                    end
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SUM: begin
                cyc_next  = CW'(alu_res);
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(3)) begin
                    state_next = ST_DIV;
                    step_next  = '0;
                    pr_next    = '0;
                end
            end
            ST_DIV: begin
                pr_next   = alu_ge ? CW'(alu_res) : CW'(pr_sh);
                sec_next  = sec_reg << 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SEC_BITS - 1)) begin
                    sec_next   = SEC_BITS'(pr_next);
                    state_next = ST_LOOP;
                    step_next  = '0;
                end
            end
            ST_FIN: begin
                rem_next     = TIME_BITS'(alu_res);
                mv_next      = 1'b1;
                go_next      = 1'b0;
                code_next    = CODE_BITS'(rem_next);
                mphase_next  = phase_reg;
                myellow_next = yellow_reg;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg  <= RESET_ORDER;
            ptime_reg  <= '{RESET_GREEN, RESET_GREEN, RESET_GREEN, RESET_GREEN};
            ytime_reg  <= RESET_YELLOW;
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            rem_reg    <= TIME_BITS'(RESET_GREEN);
            phase_reg  <= '0;
            yellow_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            order_reg  <= order_next;
            ptime_reg  <= ptime_next;
            ytime_reg  <= ytime_next;
            state_reg  <= state_next;
            step_reg   <= step_next;
            rem_reg    <= rem_next;
            phase_reg  <= phase_next;
            yellow_reg <= yellow_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        sec_reg     <= sec_next;
        cyc_reg     <= cyc_next;
        pr_reg      <= pr_next;
        go_reg      <= go_next;
        code_reg    <= code_next;
        mphase_reg  <= mphase_next;
        myellow_reg <= myellow_next;
    end

    a_tick_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_TICK) |=> !m_valid)
        else $error("tick result appeared one cycle after acceptance");

    a_query_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_QUERY) |=> m_valid)
        else $error("query result missing one cycle after acceptance");

    a_guard_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOP) |-> (step_reg <= STEP_W'(GUARD_MAX)))
        else $error("boundary step count beyond limit");

    a_remaining_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (rem_reg != '0))
        else $error("remaining time is zero while idle");

endmodule
